// ===== sv/mh64a_pkg.sv =====
// Shared types, constants and helper functions for the MurmurHash64A unit.
package mh64a_pkg;

  typedef logic [63:0] hash_t;

  localparam hash_t       MIX_MUL   = 64'hc6a4a7935bd1e995;
  localparam int unsigned MIX_SHIFT = 47;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_FULL = 2'd1;
  localparam logic [1:0] KIND_TAIL = 2'd2;

  function automatic hash_t tail_mask(input logic [2:0] nbytes);
    hash_t m;
    m = '0;
    case (nbytes)
      3'd1:    m = 64'h0000_0000_0000_00ff;
      3'd2:    m = 64'h0000_0000_0000_ffff;
      3'd3:    m = 64'h0000_0000_00ff_ffff;
      3'd4:    m = 64'h0000_0000_ffff_ffff;
      3'd5:    m = 64'h0000_00ff_ffff_ffff;
      3'd6:    m = 64'h0000_ffff_ffff_ffff;
      3'd7:    m = 64'h00ff_ffff_ffff_ffff;
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic hash_t shift_xor(input hash_t v);
    return v ^ (v >> MIX_SHIFT);
  endfunction

endpackage

// ===== sv/murmur_hash_64a_unit.sv =====
// MurmurHash64A streaming unit with one shared 32x32 multiplier.
//
// Each transaction carries up to eight message bytes; the unit is busy until the
// transaction has been absorbed. Every 64-bit multiply by the mixing constant
// runs as three passes through a single 32x32 multiplier. A full 8-byte chunk
// goes through accept, dispatch and three multiplies, a 1-7 byte tail through
// accept, dispatch and one multiply, an empty chunk through accept and dispatch;
// a first transaction adds the length multiply, a last one adds finalization
// and the result hand-off. The next transaction is taken while a finished hash
// still waits on the result channel; hash_seed is registered on cfg_wr_en.
module murmur_hash_64a_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  mh64a_pkg::hash_t   cfg_hash_seed,
  input  logic               in_valid,
  output logic               in_ready,
  input  mh64a_pkg::hash_t   in_chunk,
  input  logic [3:0]         in_chunk_bytes,
  input  logic               in_first_chunk,
  input  logic               in_last_chunk,
  input  mh64a_pkg::hash_t   in_message_length,
  output logic               out_valid,
  input  logic               out_ready,
  output mh64a_pkg::hash_t   out_hash_value
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DISP = 3'd1;
  localparam logic [2:0] ST_INIT = 3'd2;
  localparam logic [2:0] ST_K1   = 3'd3;
  localparam logic [2:0] ST_K2   = 3'd4;
  localparam logic [2:0] ST_H    = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;
  localparam logic [2:0] ST_EMIT = 3'd7;

  localparam logic [1:0] PH_LAST = 2'd2;

  logic [2:0]       state_r, state_nxt;
  logic [1:0]       ph_r, ph_nxt;
  mh64a_pkg::hash_t seed_r;
  mh64a_pkg::hash_t h_r, h_nxt;
  mh64a_pkg::hash_t a_r, a_nxt;
  mh64a_pkg::hash_t acc_r, acc_nxt;
  mh64a_pkg::hash_t chunk_r, chunk_nxt;
  logic [1:0]       kind_r, kind_nxt;
  logic             last_r, last_nxt;
  mh64a_pkg::hash_t out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             in_fire;
  logic             mul_state;
  logic             mul_done;
  logic [31:0]      op_a, op_b;
  logic [63:0]      prod;
  mh64a_pkg::hash_t res;
  logic             is_full, is_tail;

  localparam logic [31:0] MUL_LO = mh64a_pkg::MIX_MUL[31:0];
  localparam logic [31:0] MUL_HI = mh64a_pkg::MIX_MUL[63:32];

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_hash_value = out_r;

  assign mul_state = (state_r == ST_INIT) || (state_r == ST_K1) || (state_r == ST_K2) ||
                     (state_r == ST_H) || (state_r == ST_FIN);
  assign mul_done  = mul_state && (ph_r == PH_LAST);

  assign op_a = (ph_r == PH_LAST) ? a_r[63:32] : a_r[31:0];
  assign op_b = (ph_r == 2'd1) ? MUL_HI : MUL_LO;
  assign prod = {32'h0, op_a} * {32'h0, op_b};
  assign res  = acc_r + {prod[31:0], 32'h0};

  assign is_full = (in_chunk_bytes == 4'd8);
  assign is_tail = !in_chunk_bytes[3] && (in_chunk_bytes[2:0] != 3'd0);

  always_comb begin
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    h_nxt         = h_r;
    a_nxt         = a_r;
    chunk_nxt     = chunk_r;
    kind_nxt      = kind_r;
    last_nxt      = last_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    acc_nxt       = acc_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (mul_state) begin
      acc_nxt = (ph_r == 2'd0) ? prod : res;
      ph_nxt  = mul_done ? 2'd0 : ph_r + 2'd1;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          last_nxt = in_last_chunk;
          if (is_full) begin
            kind_nxt  = mh64a_pkg::KIND_FULL;
            chunk_nxt = in_chunk;
          end else if (is_tail) begin
            kind_nxt  = mh64a_pkg::KIND_TAIL;
            chunk_nxt = in_chunk & mh64a_pkg::tail_mask(in_chunk_bytes[2:0]);
          end else begin
            kind_nxt  = mh64a_pkg::KIND_NONE;
            chunk_nxt = '0;
          end
          ph_nxt = 2'd0;
          if (in_first_chunk) begin
            a_nxt     = in_message_length;
            state_nxt = ST_INIT;
          end else begin
            state_nxt = ST_DISP;
          end
        end
      end
      ST_DISP: begin
        ph_nxt = 2'd0;
        case (kind_r)
          mh64a_pkg::KIND_FULL: begin
            a_nxt     = chunk_r;
            state_nxt = ST_K1;
          end
          mh64a_pkg::KIND_TAIL: begin
            a_nxt     = h_r ^ chunk_r;
            state_nxt = ST_H;
          end
          default: begin
            if (last_r) begin
              a_nxt     = mh64a_pkg::shift_xor(h_r);
              state_nxt = ST_FIN;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
        endcase
      end
      ST_INIT: begin
        if (mul_done) begin
          h_nxt     = seed_r ^ res;
          state_nxt = ST_DISP;
        end
      end
      ST_K1: begin
        if (mul_done) begin
          a_nxt     = mh64a_pkg::shift_xor(res);
          state_nxt = ST_K2;
        end
      end
      ST_K2: begin
        if (mul_done) begin
          a_nxt     = h_r ^ res;
          state_nxt = ST_H;
        end
      end
      ST_H: begin
        if (mul_done) begin
          h_nxt = res;
          if (last_r) begin
            a_nxt     = mh64a_pkg::shift_xor(res);
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_FIN: begin
        if (mul_done) begin
          a_nxt     = mh64a_pkg::shift_xor(res);
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = a_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ph_r        <= 2'd0;
      seed_r      <= '0;
      h_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      h_r         <= h_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        seed_r <= cfg_hash_seed;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r     <= a_nxt;
    acc_r   <= acc_nxt;
    chunk_r <= chunk_nxt;
    kind_r  <= kind_nxt;
    last_r  <= last_nxt;
    out_r   <= out_nxt;
  end

endmodule

// ===== sv/mh64a_checker.sv =====
// Port-level checks for the MurmurHash64A unit, bound into the unit module.
module mh64a_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_last_chunk,
  input logic             out_valid,
  input logic             out_ready,
  input mh64a_pkg::hash_t out_hash_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hash_value))
    else $error("result changed or dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after a transaction was accepted");

  a_no_result_without_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_last_chunk && !out_valid |=> !out_valid)
    else $error("result raised by a non-last transaction");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result raised while idle");

endmodule

bind murmur_hash_64a_unit mh64a_checker u_mh64a_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_last_chunk  (in_last_chunk),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_hash_value (out_hash_value)
);
